[rtl/irb_pkg.sv]
// Shared types and constants for the image rebin unit.
`default_nettype none
package irb_pkg;
    localparam int MaxWidth  = 4096;
    localparam int MaxFactor = 8;
    localparam int ColW      = 12;
    localparam int SumW      = 38;
    localparam int CntW      = 7;

    localparam logic [1:0] RegEnlarge = 2'd0;
    localparam logic [1:0] RegFactor  = 2'd1;
    localparam logic [1:0] RegWidth   = 2'd2;
    localparam logic [1:0] RegHeight  = 2'd3;

    typedef enum logic [1:0] {
        OP_COPY,
        OP_AVG
    } op_t;

    // Classified job passed from front to back.
    typedef struct packed {
        op_t          op;
        logic [31:0]  value;
        logic         missing;
        logic [SumW-1:0] sum;
        logic [CntW-1:0] cnt;
        logic [3:0]   copies;
        logic         eof;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } bk_state_t;
endpackage
`default_nettype wire

[rtl/irb_front.sv]
// Front end: position tracking, accumulator and row stores, job classification.
`default_nettype none
module irb_front
    import irb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        in_mode,
    input  wire logic [31:0] in_value,
    input  wire logic        in_missing,
    output logic             job_valid,
    output job_t             job,
    input  wire logic        job_ready
);
    logic        enlarge_reg;
    logic [3:0]  factor_reg;
    logic [12:0] width_reg, height_reg;
    logic [ColW-1:0] col_reg, row_reg, rcol_reg, bc_reg;
    logic [2:0]  rib_reg, ci_reg, pass_reg;
    logic        cfg_wait_reg;

    logic [SumW-1:0] sums [MaxWidth];
    logic [CntW-1:0] cnts [MaxWidth];
    logic [32:0]     rows [MaxWidth];

    // stage 1 capture
    logic        s1_reg;
    logic        s1_kind_reg; // 0 shrink pixel, 1 replay read
    logic        s1_clr_reg, s1_fin_reg, s1_eof_reg;
    logic [31:0] s1_val_reg;
    logic        s1_miss_reg;
    logic [ColW-1:0] s1_addr_reg;
    logic [SumW-1:0] rd_sum_reg;
    logic [CntW-1:0] rd_cnt_reg;
    logic [32:0]     rd_row_reg;

    logic [3:0]  f;
    logic [12:0] w, h;
    logic [12:0] onx, ony;
    logic        fire;
    logic        busy;

    always_comb
    begin
        f = (factor_reg == 4'd0) ? 4'd1 : (factor_reg > 4'd8) ? 4'd8 : factor_reg;
        w = (width_reg == 13'd0) ? 13'd1 : (width_reg > 13'd4096) ? 13'd4096 : width_reg;
        h = (height_reg == 13'd0) ? 13'd1 : (height_reg > 13'd4096) ? 13'd4096 : height_reg;
    end

    // block counts, built by a small table of constant divisors
    function automatic logic [12:0] div_f(input logic [12:0] x, input logic [3:0] d);
        unique case (d)
            4'd1: div_f = x;
            4'd2: div_f = x >> 1;
            4'd4: div_f = x >> 2;
            4'd8: div_f = x >> 3;
            4'd3: div_f = 13'((27'(x) * 27'd10923) >> 15);
            4'd5: div_f = 13'((27'(x) * 27'd13108) >> 16);
            4'd6: div_f = 13'((27'(x) * 27'd10923) >> 16);
            4'd7: div_f = 13'((27'(x) * 27'd18725) >> 17);
            default: div_f = x;
        endcase
    endfunction

    logic [12:0] onx_reg, ony_reg;
    assign onx = onx_reg;
    assign ony = ony_reg;

    // block counts are registered again from the configuration registers after a write
    assign busy = s1_reg || (job_valid && !job_ready) || cfg_valid || cfg_wait_reg;
    assign in_ready = !busy;
    assign cfg_ready = 1'b1;
    assign fire = in_valid && in_ready;

    logic last_col, last_row, in_region;
    assign last_col = ({1'b0, col_reg} == w - 13'd1);
    assign last_row = ({1'b0, row_reg} == h - 13'd1);
    assign in_region = ({1'b0, col_reg} < 13'(onx * f)) && ({1'b0, row_reg} < 13'(ony * f));

    job_t        jq_reg;
    logic        jv_reg;
    assign job_valid = jv_reg;
    assign job = jq_reg;

    logic [SumW-1:0] acc_sum;
    logic [CntW-1:0] acc_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enlarge_reg <= 1'b0;
            factor_reg  <= 4'd2;
            width_reg   <= 13'd4096;
            height_reg  <= 13'd4096;
            onx_reg <= 13'd2048;
            ony_reg <= 13'd2048;
            col_reg <= '0; row_reg <= '0; rcol_reg <= '0; bc_reg <= '0;
            rib_reg <= '0; ci_reg <= '0; pass_reg <= '0;
            cfg_wait_reg <= 1'b0;
            s1_reg <= 1'b0;
            jv_reg <= 1'b0;
        end
        else
        begin
            onx_reg <= div_f(w, f);
            ony_reg <= div_f(h, f);
            cfg_wait_reg <= cfg_valid;
            if (job_valid && job_ready) jv_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    RegEnlarge: enlarge_reg <= cfg_data[0];
                    RegFactor:  factor_reg  <= cfg_data[3:0];
                    RegWidth:   width_reg   <= cfg_data;
                    RegHeight:  height_reg  <= cfg_data;
                    default: ;
                endcase
                col_reg <= '0; row_reg <= '0; rcol_reg <= '0; bc_reg <= '0;
                rib_reg <= '0; ci_reg <= '0; pass_reg <= '0;
            end
            else if (fire)
            begin
                s1_reg <= 1'b0;
                if (!enlarge_reg)
                begin
                    if (!in_mode)
                    begin
                        if (in_region)
                        begin
                            s1_reg      <= 1'b1;
                            s1_kind_reg <= 1'b0;
                            s1_clr_reg  <= (rib_reg == 3'd0) && (ci_reg == 3'd0);
                            s1_fin_reg  <= ({1'b0, rib_reg} == f - 4'd1) &&
                                           ({1'b0, ci_reg} == f - 4'd1);
                            s1_eof_reg  <= ({1'b0, bc_reg} == onx - 13'd1) &&
                                           ({1'b0, row_reg} >= 13'((ony - 13'd1) * f));
                            s1_val_reg  <= in_value;
                            s1_miss_reg <= in_missing;
                            s1_addr_reg <= bc_reg;
                        end
                        // advance
                        if (last_col)
                        begin
                            col_reg <= '0; ci_reg <= '0; bc_reg <= '0;
                            if (last_row)
                            begin
                                row_reg <= '0; rib_reg <= '0;
                            end
                            else
                            begin
                                row_reg <= row_reg + 1'b1;
                                rib_reg <= ({1'b0, rib_reg} == f - 4'd1) ? 3'd0 : rib_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                            if ({1'b0, ci_reg} == f - 4'd1)
                            begin
                                ci_reg <= '0; bc_reg <= bc_reg + 1'b1;
                            end
                            else
                                ci_reg <= ci_reg + 1'b1;
                        end
                    end
                end
                else if (!in_mode)
                begin
                    if (pass_reg == 3'd0)
                    begin
                        jv_reg <= 1'b1;
                        jq_reg.op <= OP_COPY;
                        jq_reg.value <= in_missing ? 32'd0 : in_value;
                        jq_reg.missing <= in_missing;
                        jq_reg.copies <= f;
                        jq_reg.eof <= (f == 4'd1) && last_col && last_row;
                        jq_reg.sum <= '0;
                        jq_reg.cnt <= '0;
                        if (last_col && f > 4'd1)
                        begin
                            pass_reg <= 3'(f - 4'd1);
                            rcol_reg <= '0;
                        end
                        if (last_col)
                        begin
                            col_reg <= '0;
                            row_reg <= last_row ? '0 : row_reg + 1'b1;
                        end
                        else
                            col_reg <= col_reg + 1'b1;
                    end
                end
                else if (pass_reg != 3'd0)
                begin
                    s1_reg      <= 1'b1;
                    s1_kind_reg <= 1'b1;
                    s1_addr_reg <= rcol_reg;
                    s1_eof_reg  <= (pass_reg == 3'd1) && ({1'b0, rcol_reg} == w - 13'd1) &&
                                   (row_reg == '0);
                    if ({1'b0, rcol_reg} == w - 13'd1)
                    begin
                        rcol_reg <= '0; pass_reg <= pass_reg - 1'b1;
                    end
                    else
                        rcol_reg <= rcol_reg + 1'b1;
                end
            end
            else if (s1_reg)
            begin
                s1_reg <= 1'b0;
                if (s1_kind_reg)
                begin
                    jv_reg <= 1'b1;
                    jq_reg.op <= OP_COPY;
                    jq_reg.value <= rd_row_reg[32] ? 32'd0 : rd_row_reg[31:0];
                    jq_reg.missing <= rd_row_reg[32];
                    jq_reg.copies <= f;
                    jq_reg.eof <= s1_eof_reg;
                    jq_reg.sum <= '0; jq_reg.cnt <= '0;
                end
                else if (s1_fin_reg)
                begin
                    jv_reg <= 1'b1;
                    jq_reg.op <= OP_AVG;
                    jq_reg.value <= '0;
                    jq_reg.missing <= 1'b0;
                    jq_reg.copies <= 4'd1;
                    jq_reg.eof <= s1_eof_reg;
                    jq_reg.sum <= acc_sum;
                    jq_reg.cnt <= acc_cnt;
                end
            end
        end
    end

    always_comb
    begin
        acc_sum = s1_clr_reg ? '0 : rd_sum_reg;
        acc_cnt = s1_clr_reg ? '0 : rd_cnt_reg;
        if (!s1_miss_reg)
        begin
            acc_sum = acc_sum + {{(SumW-32){s1_val_reg[31]}}, s1_val_reg};
            acc_cnt = acc_cnt + 1'b1;
        end
    end

    // memories: read on accept; sums and counts are written back from the stage 1 registers
    always_ff @(posedge clk)
    begin
        if (fire && !enlarge_reg)
        begin
            rd_sum_reg <= sums[bc_reg];
            rd_cnt_reg <= cnts[bc_reg];
        end
        if (fire && enlarge_reg)
            rd_row_reg <= rows[rcol_reg];
        if (fire && enlarge_reg && !in_mode && pass_reg == 3'd0)
            rows[col_reg] <= {in_missing, in_value};
        if (s1_reg && !s1_kind_reg && !cfg_valid)
        begin
            sums[s1_addr_reg] <= acc_sum;
            cnts[s1_addr_reg] <= acc_cnt;
        end
    end
endmodule
`default_nettype wire

[rtl/irb_back.sv]
// Back end: serial rounding divider and replicated result emission.
`default_nettype none
module irb_back
    import irb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    input  job_t             job,
    output logic             job_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_value,
    output logic             out_missing,
    output logic             out_last,
    output logic             out_eof
);
    localparam int QW = SumW + 1;
    bk_state_t state_reg, state_next;
    logic [QW-1:0] num_reg, rem_reg;
    logic [CntW:0] den_reg;
    logic [5:0]    bit_reg;
    logic          neg_reg;
    logic [31:0]   val_reg;
    logic          miss_reg, eof_reg;
    logic [3:0]    left_reg;

    logic [QW-1:0] rem_sh;
    logic          ge;
    assign rem_sh = {rem_reg[QW-2:0], num_reg[QW-1]};
    assign ge = rem_sh >= QW'(den_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (job_valid)
                state_next = (job.op == OP_AVG && job.cnt != '0) ? BK_DIV : BK_EMIT;
            BK_DIV:  if (bit_reg == 6'd0) state_next = BK_EMIT;
            BK_EMIT: if (out_ready && left_reg == 4'd1) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready   = (state_reg == BK_IDLE);
        out_valid   = (state_reg == BK_EMIT);
        out_value   = val_reg;
        out_missing = miss_reg;
        out_last    = (left_reg == 4'd1);
        out_eof     = eof_reg && (left_reg == 4'd1);
    end

    logic [SumW-1:0] mag;
    assign mag = job.sum[SumW-1] ? -job.sum : job.sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            left_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                BK_IDLE: if (job_valid)
                begin
                    left_reg <= job.copies;
                    eof_reg  <= job.eof;
                    if (job.op == OP_AVG)
                    begin
                        miss_reg <= (job.cnt == '0);
                        val_reg  <= '0;
                        num_reg  <= {mag, 1'b0} + QW'(job.cnt);
                        rem_reg  <= '0;
                        den_reg  <= {job.cnt, 1'b0};
                        bit_reg  <= 6'(QW - 1);
                        neg_reg  <= job.sum[SumW-1];
                    end
                    else
                    begin
                        miss_reg <= job.missing;
                        val_reg  <= job.value;
                    end
                end
                BK_DIV:
                begin
                    rem_reg <= ge ? rem_sh - QW'(den_reg) : rem_sh;
                    num_reg <= {num_reg[QW-2:0], ge};
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == 6'd0)
                        val_reg <= neg_reg ? 32'd0 - {num_reg[30:0], ge}
                                           : {num_reg[30:0], ge};
                end
                BK_EMIT: if (out_ready) left_reg <= left_reg - 1'b1;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/image_rebin_box_average_unit.sv]
// Top level of the image rebin unit: stream ports, front and back ends.
// Usage:
//  s_axis carries one item per beat: tuser = mode, tdata = {missing, value}.
//  m_axis carries one result per beat: tdata = {missing, value},
//  tuser = end_of_frame, tlast = last result caused by the input item.
//  cfg writes registers 0 enlarge, 1 factor, 2 image_width, 3 image_height;
//  any write rewinds the stream to the top of a frame. Write only when idle;
//  s_axis_tready stays low during a write and the cycle after it.
// Flow:
//  Shrink pixels and replays pass through the front-end stage 1 registers
//  (store read, then update), and the front takes no new item meanwhile; an
//  enlarge pixel forms its job on accept. A finished block runs the serial
//  divider before its result beat, and the back end takes one job at a time.
//  Enlarge: factor copy beats per job, then the back end returns to idle.
//  The front holds one job ahead of the back and accepts until that slot fills.
// Reset: registers return to shrink, factor 2, 4096x4096; stores are not
//  cleared and the stream starts at row 0, column 0.
// Stall: when m_axis_tready is low the back end holds its beat, the job
//  slot fills and s_axis_tready drops until space frees.
`default_nettype none
module image_rebin_box_average_unit
    import irb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [31:0] pixel_value, [32] pixel_missing
    input  wire logic        s_axis_tuser,  // [0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [31:0] out_value, [32] out_missing
    output logic             m_axis_tlast,
    output logic             m_axis_tuser   // [0] end_of_frame
);
    logic  job_valid, job_ready, miss;
    job_t  job;
    logic [31:0] val;

    irb_front u_front (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_mode(s_axis_tuser),
        .in_value(s_axis_tdata[31:0]), .in_missing(s_axis_tdata[32]),
        .job_valid, .job, .job_ready
    );

    irb_back u_back (
        .clk, .rst_n, .job_valid, .job, .job_ready,
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_value(val), .out_missing(miss), .out_last(m_axis_tlast),
        .out_eof(m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, miss, val};
endmodule
`default_nettype wire

[rtl/irb_checker.sv]
// Port-level checker for the image rebin unit, bound to the top level.
`default_nettype none
module irb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("missing pixel with nonzero value");
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without run end");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
        else $error("pad bits set");
endmodule

bind image_rebin_box_average_unit irb_checker u_irb_checker (
    .clk, .rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tlast, .m_axis_tuser
);
`default_nettype wire
